>>> sv/tpm_pkg.sv
// Shared types and constants for the thruster PD mixer.
// Holds the value width, command letters, pulse-width levels and the structs
// passed between the PD terms, the mixer and the top level. No dependencies.
`default_nettype none

package tpm_pkg;

    // Width of every PD term, error and held pulse width.
    localparam int VALUE_WIDTH = 16;
    localparam int NUM_GAINS   = 8;
    localparam int GAIN_IDX_W  = $clog2(NUM_GAINS);
    localparam int NUM_THRUST  = 6;
    localparam int NUM_SPIN    = 4;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [7:0] cmd_t;

    // Mode letters of the command byte.
    localparam cmd_t CMD_YAW_LEFT   = 8'h61;
    localparam cmd_t CMD_YAW_RIGHT  = 8'h62;
    localparam cmd_t CMD_SURGE_FWD  = 8'h63;
    localparam cmd_t CMD_SURGE_BACK = 8'h64;
    localparam cmd_t CMD_DESCEND    = 8'h65;
    localparam cmd_t CMD_FULL_HOLD  = 8'h66;
    localparam cmd_t CMD_ASCEND     = 8'h67;

    // Pulse-width levels.
    localparam value_t PW_IDLE   = value_t'(1000);
    localparam value_t PW_TURN   = value_t'(1500);
    localparam value_t PW_CRUISE = value_t'(1600);
    localparam value_t VALUE_ZERO = value_t'(0);

    // Gain register indexes on the configuration port.
    typedef enum logic [GAIN_IDX_W-1:0] {
        GAIN_PITCH_P = 3'd0,
        GAIN_PITCH_D = 3'd1,
        GAIN_YAW_P   = 3'd2,
        GAIN_YAW_D   = 3'd3,
        GAIN_ROLL_P  = 3'd4,
        GAIN_ROLL_D  = 3'd5,
        GAIN_DEPTH_P = 3'd6,
        GAIN_DEPTH_D = 3'd7
    } gain_idx_t;

    // Held thruster pulse widths and spin directions.
    typedef struct packed {
        value_t [NUM_THRUST-1:0] thrust;
        logic   [NUM_SPIN-1:0]   spin;
    } hold_t;

    // The four PD terms of one tick.
    typedef struct packed {
        value_t pitch;
        value_t yaw;
        value_t roll;
        value_t heave;
    } terms_t;

    // Mixer result: next held outputs and reference recapture requests.
    typedef struct packed {
        hold_t hold;
        logic  heading_capture;
        logic  depth_capture;
    } mix_t;

    // One input transaction as held in the input register.
    typedef struct packed {
        logic   command_valid;
        cmd_t   command_byte;
        value_t pitch_angle;
        value_t pitch_rate;
        value_t yaw_angle;
        value_t yaw_rate;
        value_t roll_angle;
        value_t roll_rate;
        value_t depth_position;
        value_t depth_velocity;
    } item_t;

endpackage

`default_nettype wire

>>> sv/thruster_pd_mixer.sv
// Thruster PD mixer top level. An accepted transaction waits in the input
// register and moves on into the output register once the output slot is
// free. Throughput: one transaction per cycle while the output is not
// stalled; an input register ahead of the output register lets one more
// transaction in while a result is stalled. Reset clears the gains, the held
// command, the references and the spins and sets every pulse width to 1000.
`default_nettype none

module thruster_pd_mixer (
    input  wire                   clk,
    input  wire                   rst_n,
    // Configuration port.
    input  wire                   cfg_wr_en,
    input  wire [tpm_pkg::GAIN_IDX_W-1:0] cfg_index,
    input  tpm_pkg::value_t       cfg_data,
    // Input channel.
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire                   command_valid,
    input  tpm_pkg::cmd_t         command_byte,
    input  tpm_pkg::value_t       pitch_angle,
    input  tpm_pkg::value_t       pitch_rate,
    input  tpm_pkg::value_t       yaw_angle,
    input  tpm_pkg::value_t       yaw_rate,
    input  tpm_pkg::value_t       roll_angle,
    input  tpm_pkg::value_t       roll_rate,
    input  tpm_pkg::value_t       depth_position,
    input  tpm_pkg::value_t       depth_velocity,
    // Output channel.
    output logic                  out_valid,
    input  wire                   out_stall,
    output tpm_pkg::value_t       thrust_one,
    output tpm_pkg::value_t       thrust_two,
    output tpm_pkg::value_t       thrust_three,
    output tpm_pkg::value_t       thrust_four,
    output tpm_pkg::value_t       thrust_five,
    output tpm_pkg::value_t       thrust_six,
    output logic                  spin_one,
    output logic                  spin_two,
    output logic                  spin_three,
    output logic                  spin_four
);
    import tpm_pkg::*;

    value_t gain_reg [NUM_GAINS];
    item_t  item_reg;
    logic   item_valid_reg;
    logic   out_valid_reg;
    hold_t  hold_reg;
    cmd_t   held_command_reg, held_command_next;
    value_t heading_ref_reg, depth_ref_reg;
    logic   refs_loaded_reg;
    value_t heading_ref_eff, depth_ref_eff;
    value_t yaw_error, depth_error;
    terms_t terms;
    mix_t   mix;
    logic   in_accept, advance;

    // Gain registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_GAINS; i++)
            begin
                gain_reg[i] <= VALUE_ZERO;
            end
        end
        else if (cfg_wr_en)
        begin
            gain_reg[cfg_index] <= cfg_data;
        end
    end

    // Handshake: the input register moves on whenever the output slot frees.
    assign advance   = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.command_valid  <= command_valid;
            item_reg.command_byte   <= command_byte;
            item_reg.pitch_angle    <= pitch_angle;
            item_reg.pitch_rate     <= pitch_rate;
            item_reg.yaw_angle      <= yaw_angle;
            item_reg.yaw_rate       <= yaw_rate;
            item_reg.roll_angle     <= roll_angle;
            item_reg.roll_rate      <= roll_rate;
            item_reg.depth_position <= depth_position;
            item_reg.depth_velocity <= depth_velocity;
        end
    end

    // The first transaction loads the references before the errors are formed.
    assign heading_ref_eff = refs_loaded_reg ? heading_ref_reg : item_reg.yaw_angle;
    assign depth_ref_eff   = refs_loaded_reg ? depth_ref_reg : item_reg.depth_position;
    assign yaw_error   = value_t'(item_reg.yaw_angle - heading_ref_eff);
    assign depth_error = value_t'(item_reg.depth_position - depth_ref_eff);

    assign held_command_next = item_reg.command_valid ? item_reg.command_byte
                                                      : held_command_reg;

    // PD terms.
    tpm_pd_term u_pitch_term (
        .gain_p (gain_reg[GAIN_PITCH_P]),
        .gain_d (gain_reg[GAIN_PITCH_D]),
        .error  (item_reg.pitch_angle),
        .rate   (item_reg.pitch_rate),
        .term   (terms.pitch)
    );

    tpm_pd_term u_yaw_term (
        .gain_p (gain_reg[GAIN_YAW_P]),
        .gain_d (gain_reg[GAIN_YAW_D]),
        .error  (yaw_error),
        .rate   (item_reg.yaw_rate),
        .term   (terms.yaw)
    );

    tpm_pd_term u_roll_term (
        .gain_p (gain_reg[GAIN_ROLL_P]),
        .gain_d (gain_reg[GAIN_ROLL_D]),
        .error  (item_reg.roll_angle),
        .rate   (item_reg.roll_rate),
        .term   (terms.roll)
    );

    tpm_pd_term u_heave_term (
        .gain_p (gain_reg[GAIN_DEPTH_P]),
        .gain_d (gain_reg[GAIN_DEPTH_D]),
        .error  (depth_error),
        .rate   (item_reg.depth_velocity),
        .term   (terms.heave)
    );

    // Mode mixing.
    tpm_mixer u_mixer (
        .mode     (held_command_next),
        .terms    (terms),
        .hold_cur (hold_reg),
        .mix      (mix)
    );

    // Held state doubles as the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg.thrust  <= {NUM_THRUST{PW_IDLE}};
            hold_reg.spin    <= '0;
            held_command_reg <= '0;
            heading_ref_reg  <= VALUE_ZERO;
            depth_ref_reg    <= VALUE_ZERO;
            refs_loaded_reg  <= 1'b0;
        end
        else if (advance)
        begin
            hold_reg         <= mix.hold;
            held_command_reg <= held_command_next;
            heading_ref_reg  <= mix.heading_capture ? item_reg.yaw_angle : heading_ref_eff;
            depth_ref_reg    <= mix.depth_capture ? item_reg.depth_position : depth_ref_eff;
            refs_loaded_reg  <= 1'b1;
        end
    end

    // Output ports.
    assign out_valid    = out_valid_reg;
    assign thrust_one   = hold_reg.thrust[0];
    assign thrust_two   = hold_reg.thrust[1];
    assign thrust_three = hold_reg.thrust[2];
    assign thrust_four  = hold_reg.thrust[3];
    assign thrust_five  = hold_reg.thrust[4];
    assign thrust_six   = hold_reg.thrust[5];
    assign spin_one     = hold_reg.spin[0];
    assign spin_two     = hold_reg.spin[1];
    assign spin_three   = hold_reg.spin[2];
    assign spin_four    = hold_reg.spin[3];

endmodule

`default_nettype wire

>>> sv/tpm_pd_term.sv
// One PD term: kp * error + kd * rate, wrapped to the value width.
// Depends on tpm_pkg for value_t.
`default_nettype none

module tpm_pd_term (
    input  tpm_pkg::value_t gain_p,
    input  tpm_pkg::value_t gain_d,
    input  tpm_pkg::value_t error,
    input  tpm_pkg::value_t rate,
    output tpm_pkg::value_t term
);
    import tpm_pkg::*;

    logic signed [2*VALUE_WIDTH-1:0] prod_p;
    logic signed [2*VALUE_WIDTH-1:0] prod_d;

    // Only the low half of each product survives the wrap.
    assign prod_p = gain_p * error;
    assign prod_d = gain_d * rate;
    assign term   = value_t'(prod_p[VALUE_WIDTH-1:0] + prod_d[VALUE_WIDTH-1:0]);

endmodule

`default_nettype wire

>>> sv/tpm_mixer.sv
// Thruster mixer: maps the held mode and the four PD terms to the next held
// pulse widths, spin directions and reference recapture requests. Depends on tpm_pkg.
`default_nettype none

module tpm_mixer (
    input  tpm_pkg::cmd_t   mode,
    input  tpm_pkg::terms_t terms,
    input  tpm_pkg::hold_t  hold_cur,
    output tpm_pkg::mix_t   mix
);
    import tpm_pkg::*;

    value_t p, y, r, h;
    value_t pitch_pw, yaw_pw5, yaw_pw6, heave_base, heave_t3, heave_t4;
    value_t pitch_abs, roll_abs;
    logic   pitch_pos, heave_pos;

    assign p = terms.pitch;
    assign y = terms.yaw;
    assign r = terms.roll;
    assign h = terms.heave;

    // Full-hold pitch: both pitch thrusters at idle plus the term magnitude.
    assign pitch_pos = (p > VALUE_ZERO);
    assign pitch_pw  = pitch_pos ? value_t'(p + PW_IDLE) : value_t'(PW_IDLE - p);

    // Full-hold yaw: one side rises above idle.
    assign yaw_pw5 = (y > VALUE_ZERO) ? value_t'(y + PW_IDLE) : PW_IDLE;
    assign yaw_pw6 = (y > VALUE_ZERO) ? PW_IDLE : value_t'(PW_IDLE - y);

    // Full-hold heave with roll split across the two heave thrusters.
    assign heave_pos  = (h > VALUE_ZERO);
    assign heave_base = heave_pos ? value_t'(h + PW_IDLE) : value_t'(PW_IDLE - h);
    always_comb
    begin
        if (heave_pos == (r > VALUE_ZERO))
        begin
            heave_t3 = value_t'(heave_base - r);
            heave_t4 = value_t'(heave_base + r);
        end
        else
        begin
            heave_t3 = value_t'(heave_base + r);
            heave_t4 = value_t'(heave_base - r);
        end
    end

    // Magnitudes used around the cruise level.
    assign pitch_abs = pitch_pos ? p : value_t'(-p);
    assign roll_abs  = (r > VALUE_ZERO) ? r : value_t'(-r);

    // Mode selection; modes leave untouched outputs at their held values.
    always_comb
    begin
        mix.hold            = hold_cur;
        mix.heading_capture = 1'b0;
        mix.depth_capture   = 1'b0;
        case (mode)
            CMD_FULL_HOLD:
            begin
                mix.hold.thrust[0] = pitch_pw;
                mix.hold.thrust[1] = pitch_pw;
                mix.hold.spin[0]   = pitch_pos;
                mix.hold.spin[1]   = ~pitch_pos;
                mix.hold.thrust[4] = yaw_pw5;
                mix.hold.thrust[5] = yaw_pw6;
                mix.hold.thrust[2] = heave_t3;
                mix.hold.thrust[3] = heave_t4;
                mix.hold.spin[2]   = heave_pos;
                mix.hold.spin[3]   = heave_pos;
            end
            CMD_YAW_LEFT, CMD_YAW_RIGHT:
            begin
                mix.hold.thrust[0] = pitch_pw;
                mix.hold.thrust[1] = pitch_pw;
                mix.hold.spin[0]   = pitch_pos;
                mix.hold.spin[1]   = ~pitch_pos;
                mix.hold.thrust[2] = heave_t3;
                mix.hold.thrust[3] = heave_t4;
                mix.hold.spin[2]   = heave_pos;
                mix.hold.spin[3]   = heave_pos;
                mix.hold.thrust[4] = (mode == CMD_YAW_LEFT) ? PW_TURN : PW_IDLE;
                mix.hold.thrust[5] = (mode == CMD_YAW_LEFT) ? PW_IDLE : PW_TURN;
                mix.heading_capture = 1'b1;
            end
            CMD_SURGE_FWD, CMD_SURGE_BACK:
            begin
                mix.hold.thrust[4] = yaw_pw5;
                mix.hold.thrust[5] = yaw_pw6;
                mix.hold.thrust[2] = heave_t3;
                mix.hold.thrust[3] = heave_t4;
                mix.hold.spin[2]   = heave_pos;
                mix.hold.spin[3]   = heave_pos;
                mix.hold.spin[0]   = (mode == CMD_SURGE_BACK);
                mix.hold.spin[1]   = (mode == CMD_SURGE_BACK);
                if (mode == CMD_SURGE_FWD)
                begin
                    mix.hold.thrust[0] = value_t'(PW_CRUISE - pitch_abs);
                    mix.hold.thrust[1] = value_t'(PW_CRUISE + pitch_abs);
                end
                else
                begin
                    mix.hold.thrust[0] = value_t'(PW_CRUISE + pitch_abs);
                    mix.hold.thrust[1] = value_t'(PW_CRUISE - pitch_abs);
                end
            end
            CMD_DESCEND, CMD_ASCEND:
            begin
                mix.hold.thrust[0] = pitch_pw;
                mix.hold.thrust[1] = pitch_pw;
                mix.hold.spin[0]   = pitch_pos;
                mix.hold.spin[1]   = ~pitch_pos;
                mix.hold.thrust[4] = yaw_pw5;
                mix.hold.thrust[5] = yaw_pw6;
                mix.hold.spin[2]   = (mode == CMD_DESCEND);
                mix.hold.spin[3]   = (mode == CMD_DESCEND);
                if (mode == CMD_DESCEND)
                begin
                    mix.hold.thrust[2] = value_t'(PW_CRUISE - roll_abs);
                    mix.hold.thrust[3] = value_t'(PW_CRUISE + roll_abs);
                end
                else
                begin
                    mix.hold.thrust[2] = value_t'(PW_CRUISE + roll_abs);
                    mix.hold.thrust[3] = value_t'(PW_CRUISE - roll_abs);
                end
                mix.depth_capture = 1'b1;
            end
            default:
            begin
                mix.hold = hold_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/tpm_checker.sv
// Port-level checks for the thruster PD mixer, bound to the top level.
// Depends on tpm_pkg for value_t and on the top-level port names.
`default_nettype none

module tpm_checker (
    input wire             clk,
    input wire             rst_n,
    input wire             in_valid,
    input wire             in_stall,
    input wire             out_valid,
    input wire             out_stall,
    input tpm_pkg::value_t thrust_one,
    input wire             spin_three,
    input wire             spin_four
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(thrust_one))
    else $error("result payload changed while stalled");

    // The input side only stalls when both slots are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled with a free slot");

    // An accepted transaction is followed by a result on offer once it has passed the input and output registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##1 out_valid)
    else $error("accepted transaction produced no result");

    // Both heave thrusters always spin the same way.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> spin_three == spin_four)
    else $error("heave spins disagree");

endmodule

bind thruster_pd_mixer tpm_checker u_checker (.*);

`default_nettype wire

>>> tb/thruster_pd_mixer_check.sv
`timescale 1ns / 100ps
// Checker for the thruster PD mixer: watches the gain writes and both channels,
// predicts the held thruster outputs of every accepted tick and compares them.
// Depends on tpm_pkg for the value, command and hold types.

module thruster_pd_mixer_check (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_wr_en,
    input  wire [tpm_pkg::GAIN_IDX_W-1:0] cfg_index,
    input  tpm_pkg::value_t               cfg_data,
    input  wire                           in_valid,
    input  wire                           in_stall,
    input  wire                           command_valid,
    input  tpm_pkg::cmd_t                 command_byte,
    input  tpm_pkg::value_t               pitch_angle,
    input  tpm_pkg::value_t               pitch_rate,
    input  tpm_pkg::value_t               yaw_angle,
    input  tpm_pkg::value_t               yaw_rate,
    input  tpm_pkg::value_t               roll_angle,
    input  tpm_pkg::value_t               roll_rate,
    input  tpm_pkg::value_t               depth_position,
    input  tpm_pkg::value_t               depth_velocity,
    input  wire                           out_valid,
    input  wire                           out_stall,
    input  tpm_pkg::value_t               thrust_one,
    input  tpm_pkg::value_t               thrust_two,
    input  tpm_pkg::value_t               thrust_three,
    input  tpm_pkg::value_t               thrust_four,
    input  tpm_pkg::value_t               thrust_five,
    input  tpm_pkg::value_t               thrust_six,
    input  wire                           spin_one,
    input  wire                           spin_two,
    input  wire                           spin_three,
    input  wire                           spin_four,
    output int                            fail_count,
    output int                            pending,
    output int                            checked
);
    import tpm_pkg::*;

    // Shadow copy of the gains, the latched mode, the references and the holds.
    value_t gain_reg [NUM_GAINS];
    cmd_t   mode_byte;
    value_t heading_ref;
    value_t depth_ref;
    logic   refs_loaded;
    value_t pulse [NUM_THRUST];
    logic   spin_dir [NUM_SPIN];

    // Held outputs still owed by the block, oldest first.
    hold_t  pulse_queue [$];
    int     mismatches;
    int     results_seen;

    // Proportional plus derivative term, wrapped to the value width.
    function automatic value_t pd_term(value_t kp, value_t kd, value_t x, value_t rate);
        longint acc;
        acc = longint'(kp) * longint'(x) + longint'(kd) * longint'(rate);
        return value_t'(acc);
    endfunction

    // Pitch pair: direction follows the sign, width grows with the magnitude.
    function automatic void set_pitch(value_t p);
        value_t level;
        if (p > 0)
        begin
            spin_dir[0] = 1'b1;
            spin_dir[1] = 1'b0;
            level = p + PW_IDLE;
        end
        else
        begin
            spin_dir[0] = 1'b0;
            spin_dir[1] = 1'b1;
            level = PW_IDLE - p;
        end
        pulse[0] = level;
        pulse[1] = level;
    endfunction

    // Yaw pair: only the motor on the side of the error pushes.
    function automatic void set_yaw(value_t y);
        if (y > 0)
        begin
            pulse[4] = y + PW_IDLE;
            pulse[5] = PW_IDLE;
        end
        else
        begin
            pulse[4] = PW_IDLE;
            pulse[5] = PW_IDLE - y;
        end
    endfunction

    // Heave pair with the roll term split across the two motors.
    function automatic void set_heave(value_t h, value_t r);
        value_t level;
        if (h > 0)
        begin
            level = h + PW_IDLE;
            spin_dir[2] = 1'b1;
            spin_dir[3] = 1'b1;
            if (r > 0)
            begin
                pulse[2] = level - r;
                pulse[3] = level + r;
            end
            else
            begin
                pulse[2] = level + r;
                pulse[3] = level - r;
            end
        end
        else
        begin
            level = PW_IDLE - h;
            spin_dir[2] = 1'b0;
            spin_dir[3] = 1'b0;
            if (r > 0)
            begin
                pulse[2] = level + r;
                pulse[3] = level - r;
            end
            else
            begin
                pulse[2] = level - r;
                pulse[3] = level + r;
            end
        end
    endfunction

    // Cruise level on a motor pair, offset by the magnitude of the term.
    function automatic void set_cruise(int first, value_t t, logic flip);
        value_t mag;
        mag = (t > 0) ? t : -t;
        if (!flip)
        begin
            pulse[first]     = PW_CRUISE - mag;
            pulse[first + 1] = PW_CRUISE + mag;
        end
        else
        begin
            pulse[first]     = PW_CRUISE + mag;
            pulse[first + 1] = PW_CRUISE - mag;
        end
    endfunction

    // One control tick: update the shadow state and queue the held outputs.
    function automatic void mix_tick(item_t t);
        value_t p_term;
        value_t y_term;
        value_t r_term;
        value_t h_term;
        hold_t  snap;
        if (!refs_loaded)
        begin
            heading_ref = t.yaw_angle;
            depth_ref   = t.depth_position;
            refs_loaded = 1'b1;
        end
        if (t.command_valid)
            mode_byte = t.command_byte;

        p_term = pd_term(gain_reg[GAIN_PITCH_P], gain_reg[GAIN_PITCH_D],
                         t.pitch_angle, t.pitch_rate);
        y_term = pd_term(gain_reg[GAIN_YAW_P], gain_reg[GAIN_YAW_D],
                         value_t'(t.yaw_angle - heading_ref), t.yaw_rate);
        r_term = pd_term(gain_reg[GAIN_ROLL_P], gain_reg[GAIN_ROLL_D],
                         t.roll_angle, t.roll_rate);
        h_term = pd_term(gain_reg[GAIN_DEPTH_P], gain_reg[GAIN_DEPTH_D],
                         value_t'(t.depth_position - depth_ref), t.depth_velocity);

        case (mode_byte)
            CMD_FULL_HOLD:
            begin
                set_pitch(p_term);
                set_yaw(y_term);
                set_heave(h_term, r_term);
            end
            CMD_YAW_LEFT, CMD_YAW_RIGHT:
            begin
                set_pitch(p_term);
                set_heave(h_term, r_term);
                pulse[4] = (mode_byte == CMD_YAW_LEFT) ? PW_TURN : PW_IDLE;
                pulse[5] = (mode_byte == CMD_YAW_LEFT) ? PW_IDLE : PW_TURN;
                heading_ref = t.yaw_angle;
            end
            CMD_SURGE_FWD, CMD_SURGE_BACK:
            begin
                set_yaw(y_term);
                set_heave(h_term, r_term);
                spin_dir[0] = (mode_byte == CMD_SURGE_BACK);
                spin_dir[1] = (mode_byte == CMD_SURGE_BACK);
                set_cruise(0, p_term, mode_byte == CMD_SURGE_BACK);
            end
            CMD_DESCEND, CMD_ASCEND:
            begin
                set_pitch(p_term);
                set_yaw(y_term);
                spin_dir[2] = (mode_byte == CMD_DESCEND);
                spin_dir[3] = (mode_byte == CMD_DESCEND);
                set_cruise(2, r_term, mode_byte == CMD_ASCEND);
                depth_ref = t.depth_position;
            end
            default:
            begin
            end
        endcase

        for (int k = 0; k < NUM_THRUST; k++)
            snap.thrust[k] = pulse[k];
        for (int k = 0; k < NUM_SPIN; k++)
            snap.spin[k] = spin_dir[k];
        pulse_queue.push_back(snap);
    endfunction

    // Sample both channels at the edge; results are checked before new ticks queue.
    always @(posedge clk or negedge rst_n)
    begin
        hold_t got;
        hold_t want;
        item_t tick;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_GAINS; k++)
                gain_reg[k] = VALUE_ZERO;
            mode_byte   = '0;
            heading_ref = VALUE_ZERO;
            depth_ref   = VALUE_ZERO;
            refs_loaded = 1'b0;
            for (int k = 0; k < NUM_THRUST; k++)
                pulse[k] = PW_IDLE;
            for (int k = 0; k < NUM_SPIN; k++)
                spin_dir[k] = 1'b0;
            pulse_queue.delete();
            mismatches   = 0;
            results_seen = 0;
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                gain_reg[cfg_index] = cfg_data;

            // Result transaction against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                got.thrust[0] = thrust_one;
                got.thrust[1] = thrust_two;
                got.thrust[2] = thrust_three;
                got.thrust[3] = thrust_four;
                got.thrust[4] = thrust_five;
                got.thrust[5] = thrust_six;
                got.spin      = {spin_four, spin_three, spin_two, spin_one};
                results_seen++;
                if (pulse_queue.size() == 0)
                begin
                    $display("%0t: result transaction with no tick outstanding", $time);
                    mismatches++;
                end
                else
                begin
                    want = pulse_queue.pop_front();
                    for (int k = 0; k < NUM_THRUST; k++)
                    begin
                        if (got.thrust[k] !== want.thrust[k])
                        begin
                            $display("%0t: thrust %0d expected %0d, got %0d",
                                     $time, k + 1, want.thrust[k], got.thrust[k]);
                            mismatches++;
                        end
                    end
                    for (int k = 0; k < NUM_SPIN; k++)
                    begin
                        if (got.spin[k] !== want.spin[k])
                        begin
                            $display("%0t: spin %0d expected %0b, got %0b",
                                     $time, k + 1, want.spin[k], got.spin[k]);
                            mismatches++;
                        end
                    end
                end
            end

            // Input transaction: predict its held outputs.
            if (in_valid && !in_stall)
            begin
                tick.command_valid  = command_valid;
                tick.command_byte   = command_byte;
                tick.pitch_angle    = pitch_angle;
                tick.pitch_rate     = pitch_rate;
                tick.yaw_angle      = yaw_angle;
                tick.yaw_rate       = yaw_rate;
                tick.roll_angle     = roll_angle;
                tick.roll_rate      = roll_rate;
                tick.depth_position = depth_position;
                tick.depth_velocity = depth_velocity;
                mix_tick(tick);
            end

            fail_count <= mismatches;
            pending    <= pulse_queue.size();
            checked    <= results_seen;
        end
    end

endmodule

>>> tb/thruster_pd_mixer_test.sv
`timescale 1ns / 100ps
// Testbench top for the thruster PD mixer: clock, reset, gain programming,
// tick stimulus, output stalls and the verdict. Uses tpm_pkg, the block and
// the checker in thruster_pd_mixer_check.sv.

module thruster_pd_mixer_test;
    import tpm_pkg::*;

    localparam int   HALF_PERIOD     = 6;
    localparam int   STALL_LIMIT     = 2000;
    localparam int   CHOKE_CYCLES    = 300;
    localparam int   RANDOM_PHASES   = 6;
    localparam int   ITEMS_PER_PHASE = 150;
    localparam value_t V_MAX         = value_t'(32767);
    localparam value_t V_MIN         = value_t'(-32768);
    // Bytes that name no mode.
    localparam cmd_t NOT_A_MODE      = 8'h7A;
    localparam cmd_t BYTE_ALL_ONES   = 8'hFF;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [GAIN_IDX_W-1:0] cfg_index;
    value_t cfg_data;
    logic   in_valid;
    logic   in_stall;
    logic   command_valid;
    cmd_t   command_byte;
    value_t pitch_angle;
    value_t pitch_rate;
    value_t yaw_angle;
    value_t yaw_rate;
    value_t roll_angle;
    value_t roll_rate;
    value_t depth_position;
    value_t depth_velocity;
    logic   out_valid;
    logic   out_stall;
    value_t thrust_one;
    value_t thrust_two;
    value_t thrust_three;
    value_t thrust_four;
    value_t thrust_five;
    value_t thrust_six;
    logic   spin_one;
    logic   spin_two;
    logic   spin_three;
    logic   spin_four;
    int     fail_count;
    int     pending;
    int     checked;

    // Stimulus controls shared with the receiver process.
    bit     sender_idles;
    bit     receiver_idles;
    bit     choke_req;
    value_t gain_plan [NUM_GAINS];
    int     gain_settings;

    always #HALF_PERIOD clk = ~clk;

    thruster_pd_mixer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command_valid  (command_valid),
        .command_byte   (command_byte),
        .pitch_angle    (pitch_angle),
        .pitch_rate     (pitch_rate),
        .yaw_angle      (yaw_angle),
        .yaw_rate       (yaw_rate),
        .roll_angle     (roll_angle),
        .roll_rate      (roll_rate),
        .depth_position (depth_position),
        .depth_velocity (depth_velocity),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .thrust_one     (thrust_one),
        .thrust_two     (thrust_two),
        .thrust_three   (thrust_three),
        .thrust_four    (thrust_four),
        .thrust_five    (thrust_five),
        .thrust_six     (thrust_six),
        .spin_one       (spin_one),
        .spin_two       (spin_two),
        .spin_three     (spin_three),
        .spin_four      (spin_four)
    );

    thruster_pd_mixer_check i_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command_valid  (command_valid),
        .command_byte   (command_byte),
        .pitch_angle    (pitch_angle),
        .pitch_rate     (pitch_rate),
        .yaw_angle      (yaw_angle),
        .yaw_rate       (yaw_rate),
        .roll_angle     (roll_angle),
        .roll_rate      (roll_rate),
        .depth_position (depth_position),
        .depth_velocity (depth_velocity),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .thrust_one     (thrust_one),
        .thrust_two     (thrust_two),
        .thrust_three   (thrust_three),
        .thrust_four    (thrust_four),
        .thrust_five    (thrust_five),
        .thrust_six     (thrust_six),
        .spin_one       (spin_one),
        .spin_two       (spin_two),
        .spin_three     (spin_three),
        .spin_four      (spin_four),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked)
    );

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sensor reading: zero, an extreme, a small value near zero, or anything.
    function automatic value_t rand_sensor();
        case ($urandom_range(0, 9))
            0:       return VALUE_ZERO;
            1:       return V_MIN;
            2:       return V_MAX;
            3, 4, 5: return value_t'(int'($urandom_range(0, 40)) - 20);
            default: return value_t'($urandom);
        endcase
    endfunction

    // Offer one tick and hold it until the block takes the transaction.
    task automatic offer_tick(input logic cv, input cmd_t cb,
                              input value_t s_pa, input value_t s_pr,
                              input value_t s_ya, input value_t s_yr,
                              input value_t s_ra, input value_t s_rr,
                              input value_t s_dp, input value_t s_dv);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        command_valid  <= cv;
        command_byte   <= cb;
        pitch_angle    <= s_pa;
        pitch_rate     <= s_pr;
        yaw_angle      <= s_ya;
        yaw_rate       <= s_yr;
        roll_angle     <= s_ra;
        roll_rate      <= s_rr;
        depth_position <= s_dp;
        depth_velocity <= s_dv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain_mixer();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all eight gains from the plan, one per cycle.
    task automatic program_gains();
        for (int k = 0; k < NUM_GAINS; k++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= gain_idx_t'(k);
            cfg_data  <= gain_plan[k];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        gain_settings++;
    endtask

    // Output side: random stalls, plus one long hold-off when asked.
    initial
    begin
        int hold_len;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (choke_req)
            begin
                choke_req = 1'b0;
                out_stall <= 1'b1;
                repeat (CHOKE_CYCLES) @(posedge clk);
            end
            else
            begin
                hold_len = receiver_idles ? pick_gap() : 0;
                if (hold_len > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold_len) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Watchdog: too many cycles without any transaction or gain write.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Main sequence: directed ticks, then random phases under fresh gains.
    initial
    begin
        logic cv;
        cmd_t cb;
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= GAIN_PITCH_P;
        cfg_data       <= VALUE_ZERO;
        in_valid       <= 1'b0;
        command_valid  <= 1'b0;
        command_byte   <= NOT_A_MODE;
        pitch_angle    <= VALUE_ZERO;
        pitch_rate     <= VALUE_ZERO;
        yaw_angle      <= VALUE_ZERO;
        yaw_rate       <= VALUE_ZERO;
        roll_angle     <= VALUE_ZERO;
        roll_rate      <= VALUE_ZERO;
        depth_position <= VALUE_ZERO;
        depth_velocity <= VALUE_ZERO;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        choke_req      = 1'b0;
        gain_settings  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset gains: first tick loads the references with a mode byte but no
        // valid flag, so no mode yet; then an unknown byte, then full hold.
        offer_tick(1'b0, CMD_FULL_HOLD, 11, -7, 1234, 5, -9, 3, -500, 8);
        offer_tick(1'b1, NOT_A_MODE, 40, 2, 1300, 0, 6, 1, -480, 0);
        offer_tick(1'b1, CMD_FULL_HOLD, 0, 0, 0, 0, 0, 0, 0, 0);

        // Small gains: each mode with the terms positive, negative or zero.
        drain_mixer();
        gain_plan[GAIN_PITCH_P] = 3;
        gain_plan[GAIN_PITCH_D] = -2;
        gain_plan[GAIN_YAW_P]   = 5;
        gain_plan[GAIN_YAW_D]   = 1;
        gain_plan[GAIN_ROLL_P]  = -4;
        gain_plan[GAIN_ROLL_D]  = 2;
        gain_plan[GAIN_DEPTH_P] = 7;
        gain_plan[GAIN_DEPTH_D] = -3;
        program_gains();
        offer_tick(1'b1, CMD_FULL_HOLD, 100, 10, 1300, -5, -20, 3, -400, 2);
        offer_tick(1'b0, CMD_YAW_LEFT, -100, 10, 900, 4, 50, 0, -700, -6);
        offer_tick(1'b1, CMD_YAW_LEFT, 100, 10, 2000, 3, -20, 3, -300, 1);
        offer_tick(1'b1, CMD_YAW_RIGHT, -100, 10, -2000, -3, 50, 0, -900, 0);
        offer_tick(1'b0, CMD_SURGE_FWD, 0, 0, 150, 0, 0, 0, -500, 0);
        offer_tick(1'b1, CMD_SURGE_FWD, 100, 10, 300, 7, -20, 3, -200, 5);
        offer_tick(1'b0, CMD_SURGE_BACK, -100, 10, -600, -7, 50, 0, -800, -5);
        offer_tick(1'b1, CMD_SURGE_BACK, 100, 10, 1300, 0, -20, 3, -400, 0);
        offer_tick(1'b1, CMD_SURGE_BACK, 0, 0, 1300, 0, 0, 0, -400, 0);
        offer_tick(1'b1, CMD_DESCEND, 100, 10, 1500, 2, -20, 3, -100, 4);
        offer_tick(1'b0, CMD_DESCEND, -100, 10, 1000, -2, 50, 0, -150, -4);
        offer_tick(1'b1, CMD_ASCEND, 100, 10, 1200, 1, -20, 3, 300, 2);
        offer_tick(1'b1, CMD_ASCEND, 0, 0, 1200, 0, 0, 0, 300, 0);
        offer_tick(1'b1, NOT_A_MODE, 300, -40, 5000, 9, 80, -9, 2000, 9);
        offer_tick(1'b1, BYTE_ALL_ONES, -300, 40, -5000, -9, -80, 9, -2000, -9);

        // Extreme gains and readings: every term wraps.
        drain_mixer();
        gain_plan[GAIN_PITCH_P] = V_MAX;
        gain_plan[GAIN_PITCH_D] = V_MIN;
        gain_plan[GAIN_YAW_P]   = V_MIN;
        gain_plan[GAIN_YAW_D]   = V_MAX;
        gain_plan[GAIN_ROLL_P]  = V_MAX;
        gain_plan[GAIN_ROLL_D]  = V_MAX;
        gain_plan[GAIN_DEPTH_P] = V_MIN;
        gain_plan[GAIN_DEPTH_D] = V_MIN;
        program_gains();
        offer_tick(1'b1, CMD_FULL_HOLD, V_MAX, V_MIN, V_MIN, V_MAX, V_MAX, V_MIN, V_MAX, V_MIN);
        offer_tick(1'b1, CMD_SURGE_FWD, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN);
        offer_tick(1'b1, CMD_DESCEND, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX);
        offer_tick(1'b1, CMD_SURGE_BACK, V_MAX, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX);
        offer_tick(1'b1, CMD_ASCEND, V_MIN, V_MAX, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN);
        offer_tick(1'b1, CMD_YAW_LEFT, V_MIN, V_MIN, V_MAX, V_MAX, V_MIN, V_MIN, V_MAX, V_MAX);

        // Random phases, each under its own gain setting and idling pattern.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_mixer();
            for (int k = 0; k < NUM_GAINS; k++)
            begin
                case (ph % 4)
                    0: gain_plan[k] = value_t'(int'($urandom_range(0, 16)) - 8);
                    1: gain_plan[k] = value_t'($urandom);
                    2:
                    begin
                        case ($urandom_range(0, 3))
                            0:       gain_plan[k] = V_MAX;
                            1:       gain_plan[k] = V_MIN;
                            2:       gain_plan[k] = 1;
                            default: gain_plan[k] = -1;
                        endcase
                    end
                    default: gain_plan[k] = value_t'(int'($urandom_range(0, 600)) - 300);
                endcase
            end
            program_gains();
            sender_idles   = (ph % 3 != 1);
            receiver_idles = (ph % 3 != 2);
            // The sender keeps pushing while the output is held off.
            choke_req      = (ph == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                cv = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) < 7)
                    cb = cmd_t'(CMD_YAW_LEFT + $urandom_range(0, 6));
                else
                    cb = cmd_t'($urandom_range(0, 255));
                offer_tick(cv, cb, rand_sensor(), rand_sensor(), rand_sensor(), rand_sensor(),
                           rand_sensor(), rand_sensor(), rand_sensor(), rand_sensor());
            end
        end
        drain_mixer();

        $display("Checked %0d result transactions under %0d gain settings,", checked,
                 gain_settings);
        $display("covering all seven modes, unknown bytes, wrapping terms and a long hold-off.");
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
sv/tpm_pkg.sv
sv/tpm_pd_term.sv
sv/tpm_mixer.sv
sv/thruster_pd_mixer.sv
sv/tpm_checker.sv
tb/thruster_pd_mixer_check.sv
tb/thruster_pd_mixer_test.sv
